@@ rtl/core/fsat_pkg.sv @@
// fsat_pkg: shared types and constants for the fragment send/ack tracker
// no dependencies; used by every file in rtl/core
package fsat_pkg;

  localparam int MAX_PARTS    = 256;
  localparam int HEADER_BYTES = 8;

  localparam int IDX_W    = $clog2(MAX_PARTS);
  localparam int CNT_W    = 8;
  localparam int LOCK_W   = 32;
  localparam int MTU_W    = 16;
  localparam int LEN_W    = 24;
  localparam int BUF_W    = 25;
  localparam int STRIDE_W = 17;
  localparam int OFF_W    = 24;
  localparam int BLEN_W   = 17;
  localparam int STAT_W   = 3;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;
  localparam int STEP_W   = $clog2(LEN_W);

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FETCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_NONE     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_CHOSEN   = 3'd1;
  localparam logic [STAT_W-1:0] STAT_ALL_ACK  = 3'd2;
  localparam logic [STAT_W-1:0] STAT_STARTED  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_MTU   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 1'd1;

  localparam logic [MTU_W-1:0]  MTU_RESET   = 16'd500;
  localparam logic [LOCK_W-1:0] DELAY_RESET = 32'd10000;

  typedef struct packed {
    logic              done;
    logic [LOCK_W-1:0] lock;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_CLEAR,
    S_SCAN,
    S_MUL,
    S_LEN,
    S_ACK
  } fsm_t;

endpackage

@@ rtl/core/fragment_send_ack_tracker_unit.sv @@
// fragment_send_ack_tracker_unit: top level, control sequencer, config and result registers
// depends on fsat_pkg, fsat_div, fsat_ram
//
//   channel  ports                                          handshake
//   request  in_mode in_now in_resend in_part_number
//            in_payload_length                              start / busy
//   result   out_status out_part_index out_byte_offset
//            out_byte_length out_part_count                 out_valid, one cycle
//   config   cfg_index cfg_wdata                            cfg_we
//
// start: divide, then entry clear (one entry per cycle)
// fetch: scan in order (one entry read per cycle) to the chosen part or the last entry, then offset and length
// ack: read, then modify and write back; other requests complete from the idle state
// synchronous reset; entry store is not cleared, start clears the entries in use
// result is registered, out_valid pulses in the cycle after the request completes, no stalls
module fragment_send_ack_tracker_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [fsat_pkg::MODE_W-1:0]      in_mode,
  input  logic [fsat_pkg::LOCK_W-1:0]      in_now,
  input  logic                             in_resend,
  input  logic [fsat_pkg::CNT_W-1:0]       in_part_number,
  input  logic [fsat_pkg::LEN_W-1:0]       in_payload_length,
  output logic                             out_valid,
  output logic [fsat_pkg::STAT_W-1:0]      out_status,
  output logic [fsat_pkg::IDX_W-1:0]       out_part_index,
  output logic [fsat_pkg::OFF_W-1:0]       out_byte_offset,
  output logic [fsat_pkg::BLEN_W-1:0]      out_byte_length,
  output logic [fsat_pkg::CNT_W-1:0]       out_part_count,
  input  logic                             cfg_we,
  input  logic [fsat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fsat_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  fsat_pkg::fsm_t state_r, state_nxt;

  logic [fsat_pkg::MTU_W-1:0]   mtu_r;
  logic [fsat_pkg::LOCK_W-1:0]  delay_r;

  logic [fsat_pkg::LOCK_W-1:0]  now_r;
  logic                         resend_r;
  logic [fsat_pkg::LEN_W-1:0]   len_r;

  logic [fsat_pkg::CNT_W-1:0]   total_r;
  logic [fsat_pkg::CNT_W-1:0]   unacked_r;
  logic [fsat_pkg::BUF_W-1:0]   buf_r;
  logic                         ready_r;
  logic                         ovf_r;

  logic [fsat_pkg::IDX_W-1:0]   clr_idx_r;
  logic [fsat_pkg::CNT_W-1:0]   scan_idx_r;
  logic                         pend_r;
  logic [fsat_pkg::IDX_W-1:0]   pend_idx_r;
  logic [fsat_pkg::IDX_W-1:0]   hit_idx_r;
  logic [fsat_pkg::BUF_W-1:0]   off_r;

  logic                         out_valid_r;
  logic [fsat_pkg::STAT_W-1:0]  out_status_r;
  logic [fsat_pkg::IDX_W-1:0]   out_idx_r;
  logic [fsat_pkg::OFF_W-1:0]   out_off_r;
  logic [fsat_pkg::BLEN_W-1:0]  out_len_r;
  logic [fsat_pkg::CNT_W-1:0]   out_cnt_r;

  logic                         accept;
  logic                         ack_ok;
  logic                         fetch_ok;

  logic                         div_go;
  logic                         div_done;
  logic [fsat_pkg::LEN_W-1:0]   div_q;
  logic [fsat_pkg::MTU_W-1:0]   div_r;
  logic [fsat_pkg::MTU_W-1:0]   divisor;
  logic [fsat_pkg::BUF_W-1:0]   full;
  logic [fsat_pkg::CNT_W-1:0]   cnt;
  logic                         ovf;

  logic                         mem_we;
  logic [fsat_pkg::IDX_W-1:0]   mem_waddr;
  fsat_pkg::ent_t               mem_wdata;
  logic                         mem_re;
  logic [fsat_pkg::IDX_W-1:0]   mem_raddr;
  fsat_pkg::ent_t               mem_rdata;

  logic                         issue;
  logic [fsat_pkg::LOCK_W-1:0]  lock_due;
  logic                         due;
  logic                         scan_hit;
  logic                         scan_end;
  logic                         clr_last;

  logic [fsat_pkg::STRIDE_W-1:0] stride;
  logic [fsat_pkg::BUF_W-1:0]    diff;
  logic [fsat_pkg::BLEN_W-1:0]   part_len;

  logic                         fin;
  logic [fsat_pkg::STAT_W-1:0]  fin_status;

  // request decode
  assign busy     = state_r != fsat_pkg::S_IDLE;
  assign accept   = start && !busy;
  assign fetch_ok = ready_r && (total_r != '0);
  assign ack_ok   = ready_r && (in_part_number != '0) && (in_part_number <= total_r)
                    && (unacked_r != '0);

  // part count from the divider
  assign divisor = (mtu_r == '0) ? fsat_pkg::MTU_W'(1) : mtu_r;
  assign div_go  = accept && (in_mode == fsat_pkg::MODE_START);
  assign full    = {1'b0, div_q} + fsat_pkg::BUF_W'(div_r != '0);
  assign cnt     = full[fsat_pkg::CNT_W-1:0];
  assign ovf     = |full[fsat_pkg::BUF_W-1:fsat_pkg::CNT_W];

  // scan evaluation
  assign issue    = (state_r == fsat_pkg::S_SCAN) && (scan_idx_r < total_r);
  assign lock_due = mem_rdata.lock + delay_r;
  assign due      = !mem_rdata.done &&
                    (resend_r ? (now_r >= lock_due) : (mem_rdata.lock == '0));
  assign scan_hit = pend_r && due;
  assign scan_end = pend_r && !due &&
                    (fsat_pkg::CNT_W'(pend_idx_r) == total_r - 1'b1);
  assign clr_last = fsat_pkg::CNT_W'(clr_idx_r) == total_r - 1'b1;

  // part length from offset
  assign stride   = {1'b0, mtu_r} + fsat_pkg::STRIDE_W'(fsat_pkg::HEADER_BYTES);
  assign diff     = buf_r - off_r;
  assign part_len = (buf_r <= off_r) ? '0 :
                    (diff > fsat_pkg::BUF_W'(stride)) ? stride : diff[fsat_pkg::BLEN_W-1:0];

  fsat_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (in_payload_length),
    .divisor   (divisor),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  fsat_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsat_pkg::S_IDLE: begin
        if (accept) begin
          priority if (in_mode == fsat_pkg::MODE_START) begin
            state_nxt = fsat_pkg::S_DIV;
          end else if (in_mode == fsat_pkg::MODE_FETCH && fetch_ok) begin
            state_nxt = fsat_pkg::S_SCAN;
          end else if (in_mode == fsat_pkg::MODE_ACK && ack_ok) begin
            state_nxt = fsat_pkg::S_ACK;
          end else begin
            state_nxt = fsat_pkg::S_IDLE;
          end
        end
      end
      fsat_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = (cnt == '0) ? fsat_pkg::S_IDLE : fsat_pkg::S_CLEAR;
        end
      end
      fsat_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = fsat_pkg::S_IDLE;
        end
      end
      fsat_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_nxt = fsat_pkg::S_MUL;
        end else if (scan_end) begin
          state_nxt = fsat_pkg::S_IDLE;
        end
      end
      fsat_pkg::S_MUL: state_nxt = fsat_pkg::S_LEN;
      fsat_pkg::S_LEN: state_nxt = fsat_pkg::S_IDLE;
      fsat_pkg::S_ACK: state_nxt = fsat_pkg::S_IDLE;
      default:         state_nxt = fsat_pkg::S_IDLE;
    endcase
  end

  // memory control and completion
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    fin        = 1'b0;
    fin_status = fsat_pkg::STAT_NONE;
    unique case (state_r)
      fsat_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == fsat_pkg::MODE_ACK && ack_ok) begin
            mem_re    = 1'b1;
            mem_raddr = in_part_number - 1'b1;
          end
          if (!(in_mode == fsat_pkg::MODE_START) &&
              !(in_mode == fsat_pkg::MODE_FETCH && fetch_ok) &&
              !(in_mode == fsat_pkg::MODE_ACK && ack_ok)) begin
            fin = 1'b1;
          end
        end
      end
      fsat_pkg::S_DIV: begin
        if (div_done && cnt == '0) begin
          fin        = 1'b1;
          fin_status = ovf ? fsat_pkg::STAT_OVERFLOW : fsat_pkg::STAT_STARTED;
        end
      end
      fsat_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        if (clr_last) begin
          fin        = 1'b1;
          fin_status = ovf_r ? fsat_pkg::STAT_OVERFLOW : fsat_pkg::STAT_STARTED;
        end
      end
      fsat_pkg::S_SCAN: begin
        mem_re    = issue;
        mem_raddr = scan_idx_r[fsat_pkg::IDX_W-1:0];
        if (scan_hit) begin
          mem_we         = 1'b1;
          mem_waddr      = pend_idx_r;
          mem_wdata.done = !resend_r;
          mem_wdata.lock = resend_r ? now_r : mem_rdata.lock;
        end else if (scan_end) begin
          fin = 1'b1;
        end
      end
      fsat_pkg::S_MUL: begin
      end
      fsat_pkg::S_LEN: begin
        fin        = 1'b1;
        fin_status = fsat_pkg::STAT_CHOSEN;
      end
      fsat_pkg::S_ACK: begin
        fin = 1'b1;
        if (!mem_rdata.done) begin
          mem_we         = 1'b1;
          mem_waddr      = hit_idx_r;
          mem_wdata.done = 1'b1;
          mem_wdata.lock = mem_rdata.lock;
          fin_status     = (unacked_r == fsat_pkg::CNT_W'(1)) ?
                           fsat_pkg::STAT_ALL_ACK : fsat_pkg::STAT_NONE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= fsat_pkg::S_IDLE;
      mtu_r     <= fsat_pkg::MTU_RESET;
      delay_r   <= fsat_pkg::DELAY_RESET;
      total_r   <= '0;
      unacked_r <= '0;
      buf_r     <= '0;
      ready_r   <= 1'b0;
      pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (cfg_we) begin
        unique case (cfg_index)
          fsat_pkg::CFG_MTU:   mtu_r   <= cfg_wdata[fsat_pkg::MTU_W-1:0];
          fsat_pkg::CFG_DELAY: delay_r <= cfg_wdata[fsat_pkg::LOCK_W-1:0];
          default: begin
          end
        endcase
      end
      if (state_r == fsat_pkg::S_DIV && div_done) begin
        total_r   <= cnt;
        unacked_r <= cnt;
        buf_r     <= fsat_pkg::BUF_W'(len_r) +
                     fsat_pkg::BUF_W'(cnt) * fsat_pkg::BUF_W'(fsat_pkg::HEADER_BYTES);
        ready_r   <= 1'b1;
      end
      if (state_r == fsat_pkg::S_ACK && !mem_rdata.done) begin
        unacked_r <= unacked_r - 1'b1;
      end
      if (state_r == fsat_pkg::S_SCAN) begin
        pend_r <= issue;
      end else begin
        pend_r <= 1'b0;
      end
    end
  end

  // request and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r      <= in_now;
      resend_r   <= in_resend;
      len_r      <= in_payload_length;
      scan_idx_r <= '0;
      hit_idx_r  <= in_part_number - 1'b1;
    end
    if (state_r == fsat_pkg::S_DIV && div_done) begin
      ovf_r     <= ovf;
      clr_idx_r <= '0;
    end
    if (state_r == fsat_pkg::S_CLEAR) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
    if (issue) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      pend_idx_r <= scan_idx_r[fsat_pkg::IDX_W-1:0];
    end
    if (state_r == fsat_pkg::S_SCAN && scan_hit) begin
      hit_idx_r <= pend_idx_r;
    end
    if (state_r == fsat_pkg::S_MUL) begin
      off_r <= fsat_pkg::BUF_W'(hit_idx_r) * fsat_pkg::BUF_W'(stride);
    end
    if (fin) begin
      out_status_r <= fin_status;
      out_cnt_r    <= (state_r == fsat_pkg::S_DIV) ? cnt : total_r;
      if (state_r == fsat_pkg::S_LEN) begin
        out_idx_r <= hit_idx_r;
        out_off_r <= off_r[fsat_pkg::OFF_W-1:0];
        out_len_r <= part_len;
      end else begin
        out_idx_r <= '0;
        out_off_r <= '0;
        out_len_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_part_index  = out_idx_r;
  assign out_byte_offset = out_off_r;
  assign out_byte_length = out_len_r;
  assign out_part_count  = out_cnt_r;

`ifndef SYNTHESIS
  a_unacked_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    unacked_r <= total_r)
    else $error("unacknowledged count above part count");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(accept) || $past(busy)))
    else $error("result without a request in flight");

  a_chosen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == fsat_pkg::STAT_CHOSEN) |-> (out_part_index < out_part_count))
    else $error("chosen part outside the datagram");

  a_unchosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fsat_pkg::STAT_CHOSEN) |->
      (out_byte_offset == '0 && out_byte_length == '0 && out_part_index == '0))
    else $error("part fields set on a result without a chosen part");

  a_scan_needs_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fsat_pkg::S_SCAN) |-> (ready_r && total_r != '0))
    else $error("scan started without a table");
`endif

endmodule

@@ rtl/core/fsat_div.sv @@
// fsat_div: restoring divider, one quotient bit per cycle
// depends on fsat_pkg
module fsat_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [fsat_pkg::LEN_W-1:0]  dividend,
  input  logic [fsat_pkg::MTU_W-1:0]  divisor,
  output logic                        done,
  output logic [fsat_pkg::LEN_W-1:0]  quotient,
  output logic [fsat_pkg::MTU_W-1:0]  remainder
);

  logic                         busy_r;
  logic                         done_r;
  logic [fsat_pkg::STEP_W-1:0]  step_r;
  logic [fsat_pkg::LEN_W-1:0]   quo_r;
  logic [fsat_pkg::MTU_W-1:0]   rem_r;
  logic [fsat_pkg::MTU_W-1:0]   dsr_r;
  logic [fsat_pkg::MTU_W:0]     trial;
  logic [fsat_pkg::MTU_W:0]     diff;
  logic                         ge;

  assign trial = {rem_r, quo_r[fsat_pkg::LEN_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == fsat_pkg::STEP_W'(fsat_pkg::LEN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[fsat_pkg::LEN_W-2:0], ge};
      rem_r <= ge ? diff[fsat_pkg::MTU_W-1:0] : trial[fsat_pkg::MTU_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/core/fsat_ram.sv @@
// fsat_ram: per-part entry store (done bit and lock time), one write and one read port
// depends on fsat_pkg; read data is registered
module fsat_ram (
  input  logic                        clk,
  input  logic                        we,
  input  logic [fsat_pkg::IDX_W-1:0]  waddr,
  input  fsat_pkg::ent_t              wdata,
  input  logic                        re,
  input  logic [fsat_pkg::IDX_W-1:0]  raddr,
  output fsat_pkg::ent_t              rdata
);

  fsat_pkg::ent_t mem [fsat_pkg::MAX_PARTS];
  fsat_pkg::ent_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ tb/tb.sv @@
// tb: self-checking bench for fragment_send_ack_tracker_unit
// drives start/busy requests and register writes, checks each out_valid result
// against an in-bench tracker; depends on fsat_pkg
module tb;

  localparam logic [fsat_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [fsat_pkg::MODE_W-1:0] mode;
    logic [fsat_pkg::LOCK_W-1:0] now;
    logic                        resend;
    logic [fsat_pkg::CNT_W-1:0]  part_number;
    logic [fsat_pkg::LEN_W-1:0]  payload_length;
  } frag_req_t;

  typedef struct packed {
    logic [fsat_pkg::STAT_W-1:0] status;
    logic [fsat_pkg::IDX_W-1:0]  part_index;
    logic [fsat_pkg::OFF_W-1:0]  byte_offset;
    logic [fsat_pkg::BLEN_W-1:0] byte_length;
    logic [fsat_pkg::CNT_W-1:0]  part_count;
  } frag_res_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  logic [fsat_pkg::MODE_W-1:0]    in_mode = '0;
  logic [fsat_pkg::LOCK_W-1:0]    in_now = '0;
  logic                           in_resend = 1'b0;
  logic [fsat_pkg::CNT_W-1:0]     in_part_number = '0;
  logic [fsat_pkg::LEN_W-1:0]     in_payload_length = '0;
  logic                           out_valid;
  logic [fsat_pkg::STAT_W-1:0]    out_status;
  logic [fsat_pkg::IDX_W-1:0]     out_part_index;
  logic [fsat_pkg::OFF_W-1:0]     out_byte_offset;
  logic [fsat_pkg::BLEN_W-1:0]    out_byte_length;
  logic [fsat_pkg::CNT_W-1:0]     out_part_count;
  logic                           cfg_we = 1'b0;
  logic [fsat_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fsat_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  fragment_send_ack_tracker_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_now            (in_now),
    .in_resend         (in_resend),
    .in_part_number    (in_part_number),
    .in_payload_length (in_payload_length),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_part_index    (out_part_index),
    .out_byte_offset   (out_byte_offset),
    .out_byte_length   (out_byte_length),
    .out_part_count    (out_part_count),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // tracker state mirrored in the bench
  logic [fsat_pkg::MTU_W-1:0]  mtu_reg;
  logic [fsat_pkg::LOCK_W-1:0] delay_reg;
  logic [fsat_pkg::LOCK_W-1:0] lock_tbl [fsat_pkg::MAX_PARTS];
  bit                          done_tbl [fsat_pkg::MAX_PARTS];
  logic [fsat_pkg::CNT_W-1:0]  total_parts;
  logic [fsat_pkg::CNT_W-1:0]  unacked_parts;
  logic [fsat_pkg::BUF_W-1:0]  buf_bytes;
  bit                          tbl_valid;

  frag_req_t datagram_requests [$];
  frag_res_t frag_results_due [$];

  frag_req_t   next_req;
  frag_req_t   taken_req;
  frag_res_t   want_res;
  int          gap_left = 0;
  bit          req_taken = 1'b0;
  bit          gaps_on = 1'b1;
  int          fail_count = 0;
  logic [31:0] tick = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic frag_res_t predict_fragment(frag_req_t r);
    frag_res_t   res;
    logic [31:0] m, full, stride, off, blen, due;
    int          sel;
    res = '0;
    sel = -1;
    case (r.mode)
      fsat_pkg::MODE_START: begin
        m = (mtu_reg == '0) ? 32'd1 : 32'(mtu_reg);
        full = (32'(r.payload_length) + m - 32'd1) / m;
        total_parts = full[7:0];
        unacked_parts = full[7:0];
        buf_bytes = fsat_pkg::BUF_W'(32'(r.payload_length) +
                                     32'(full[7:0]) * fsat_pkg::HEADER_BYTES);
        for (int i = 0; i < int'(full[7:0]); i++) begin
          lock_tbl[i] = '0;
          done_tbl[i] = 1'b0;
        end
        tbl_valid = 1'b1;
        res.status = (full > 32'd255) ? fsat_pkg::STAT_OVERFLOW : fsat_pkg::STAT_STARTED;
      end
      fsat_pkg::MODE_FETCH: begin
        if (tbl_valid) begin
          for (int i = 0; i < int'(total_parts); i++) begin
            due = lock_tbl[i] + delay_reg;
            if (sel < 0 && !done_tbl[i] && (r.resend ? (r.now >= due) : (lock_tbl[i] == '0)))
              sel = i;
          end
          if (sel >= 0) begin
            if (r.resend)
              lock_tbl[sel] = r.now;
            else
              done_tbl[sel] = 1'b1;
            stride = 32'(mtu_reg) + fsat_pkg::HEADER_BYTES;
            off = 32'(sel) * stride;
            blen = '0;
            if (32'(buf_bytes) > off) begin
              blen = 32'(buf_bytes) - off;
              if (blen > stride)
                blen = stride;
            end
            res.status = fsat_pkg::STAT_CHOSEN;
            res.part_index = sel[7:0];
            res.byte_offset = off[fsat_pkg::OFF_W-1:0];
            res.byte_length = blen[fsat_pkg::BLEN_W-1:0];
          end
        end
      end
      fsat_pkg::MODE_ACK: begin
        if (tbl_valid && r.part_number != '0 && r.part_number <= total_parts &&
            unacked_parts != '0 && !done_tbl[r.part_number - 8'd1]) begin
          done_tbl[r.part_number - 8'd1] = 1'b1;
          unacked_parts = unacked_parts - 1'b1;
          if (unacked_parts == '0)
            res.status = fsat_pkg::STAT_ALL_ACK;
        end
      end
      default: ;
    endcase
    res.part_count = total_parts;
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (!gaps_on || pick < 50)
      return 0;
    if (pick < 85)
      return $urandom_range(1, 4);
    if (pick < 97)
      return $urandom_range(5, 40);
    return $urandom_range(100, 300);
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!(start && !req_taken)) begin
        if (req_taken)
          gap_left = pick_gap();
        req_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (datagram_requests.size() != 0) begin
          next_req = datagram_requests.pop_front();
          in_mode <= next_req.mode;
          in_now <= next_req.now;
          in_resend <= next_req.resend;
          in_part_number <= next_req.part_number;
          in_payload_length <= next_req.payload_length;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: register writes, accepted requests and results
  always @(posedge clk) begin
    if (!rst_n) begin
      mtu_reg = fsat_pkg::MTU_RESET;
      delay_reg = fsat_pkg::DELAY_RESET;
      total_parts = '0;
      unacked_parts = '0;
      buf_bytes = '0;
      tbl_valid = 1'b0;
      for (int i = 0; i < fsat_pkg::MAX_PARTS; i++) begin
        lock_tbl[i] = '0;
        done_tbl[i] = 1'b0;
      end
    end else begin
      if (out_valid) begin
        if (frag_results_due.size() == 0) begin
          flag_mismatch("result with no request outstanding, status",
                        32'(out_status), 32'd0);
        end else begin
          want_res = frag_results_due.pop_front();
          if (out_status !== want_res.status)
            flag_mismatch("status", 32'(out_status), 32'(want_res.status));
          if (out_part_index !== want_res.part_index)
            flag_mismatch("part_index", 32'(out_part_index), 32'(want_res.part_index));
          if (out_byte_offset !== want_res.byte_offset)
            flag_mismatch("byte_offset", 32'(out_byte_offset), 32'(want_res.byte_offset));
          if (out_byte_length !== want_res.byte_length)
            flag_mismatch("byte_length", 32'(out_byte_length), 32'(want_res.byte_length));
          if (out_part_count !== want_res.part_count)
            flag_mismatch("part_count", 32'(out_part_count), 32'(want_res.part_count));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          fsat_pkg::CFG_MTU:   mtu_reg = cfg_wdata[fsat_pkg::MTU_W-1:0];
          fsat_pkg::CFG_DELAY: delay_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        req_taken = 1'b1;
        taken_req = '{in_mode, in_now, in_resend, in_part_number, in_payload_length};
        frag_results_due.push_back(predict_fragment(taken_req));
      end
    end
  end

  function automatic void push_req(logic [fsat_pkg::MODE_W-1:0] mode, logic [31:0] now,
                                   logic resend, logic [7:0] pn, logic [23:0] len);
    frag_req_t r;
    r = '{mode, now, resend, pn, len};
    datagram_requests.push_back(r);
  endfunction

  function automatic frag_req_t random_req();
    frag_req_t r;
    r.mode = fsat_pkg::MODE_W'($urandom_range(0, 3));
    r.now = $urandom;
    r.resend = 1'($urandom_range(0, 1));
    r.part_number = fsat_pkg::CNT_W'($urandom_range(0, 255));
    r.payload_length = fsat_pkg::LEN_W'($urandom_range(0, 24'hFFFFFF));
    return r;
  endfunction

  function automatic logic [31:0] next_tick(logic [31:0] dly);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)
      tick = tick + $urandom_range(0, 3);
    else if (pick < 80)
      tick = tick + dly + $urandom_range(0, 2);
    else if (pick < 90)
      tick = $urandom;
    else if (pick < 95)
      tick = '1;
    else
      tick = '0;
    return tick;
  endfunction

  // one datagram: start, a mix of sends and acks, often a full ack sweep
  function automatic void queue_datagram(logic [15:0] mtu_v, logic [31:0] dly);
    frag_req_t   r;
    logic [31:0] m, len, k, ops;
    int          pick;
    m = (mtu_v == '0) ? 32'd1 : 32'(mtu_v);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      len = '0;
    end else if (pick < 10) begin
      len = $urandom & 32'hFFFFFF;
    end else begin
      if (pick < 75)
        k = $urandom_range(1, 6);
      else if (pick < 92)
        k = $urandom_range(7, 40);
      else
        k = $urandom_range(200, 255);
      len = (k - 1) * m + $urandom_range(1, m);
      if (len > 32'hFFFFFF)
        len = 32'hFFFFFF;
    end
    k = ((len + m - 1) / m) & 32'hFF;
    r = random_req();
    r.mode = fsat_pkg::MODE_START;
    r.payload_length = len[fsat_pkg::LEN_W-1:0];
    datagram_requests.push_back(r);
    ops = (k > 40) ? $urandom_range(3, 12) : 2 * k + $urandom_range(1, 4);
    for (int j = 0; j < int'(ops); j++) begin
      r = random_req();
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.mode = fsat_pkg::MODE_FETCH;
        r.resend = 1'b1;
        r.now = next_tick(dly);
      end else if (pick < 50) begin
        r.mode = fsat_pkg::MODE_FETCH;
        r.resend = 1'b0;
      end else if (pick < 85) begin
        r.mode = fsat_pkg::MODE_ACK;
        if (k != 0)
          r.part_number = fsat_pkg::CNT_W'($urandom_range(1, k));
      end else if (pick < 93) begin
        r.mode = fsat_pkg::MODE_ACK;
      end else if (pick < 96) begin
        r.mode = MODE_UNKNOWN;
      end else begin
        r.mode = fsat_pkg::MODE_FETCH;
      end
      datagram_requests.push_back(r);
    end
    if (k != 0 && k <= 40 && $urandom_range(0, 99) < 60) begin
      for (int j = 1; j <= int'(k); j++) begin
        r = random_req();
        r.mode = fsat_pkg::MODE_ACK;
        r.part_number = fsat_pkg::CNT_W'(j);
        datagram_requests.push_back(r);
      end
    end
  endfunction

  // sample after the falling-edge updates have settled
  task automatic wait_quiet();
    do begin
      @(negedge clk);
      #1;
    end while (datagram_requests.size() != 0 || start || busy ||
               frag_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_settings(logic [15:0] mtu_v, logic [31:0] dly_v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= fsat_pkg::CFG_MTU;
    cfg_wdata <= {16'($urandom), mtu_v};
    @(negedge clk);
    cfg_index <= fsat_pkg::CFG_DELAY;
    cfg_wdata <= dly_v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] mtu_v;
    logic [31:0] dly_v;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, at reset settings (mtu 500, delay 10000)
    push_req(fsat_pkg::MODE_FETCH, 32'hFFFFFFFF, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(MODE_UNKNOWN, 32'hFFFFFFFF, 1'b1, 8'hFF, 24'hFFFFFF);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd0, 1'b0, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'd1200);
    push_req(fsat_pkg::MODE_FETCH, 32'd9999, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd10000, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd10000, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd0, 1'b0, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd0, 1'b0, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd4, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd3, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(fsat_pkg::MODE_FETCH, 32'd20000, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd2, 24'd0);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'd500);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd1, 24'd0);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'hFFFFFF);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'd128000);
    push_req(fsat_pkg::MODE_FETCH, 32'd0, 1'b1, 8'd0, 24'd0);
    push_req(fsat_pkg::MODE_START, 32'd0, 1'b0, 8'd0, 24'd127500);
    push_req(fsat_pkg::MODE_ACK, 32'd0, 1'b0, 8'd255, 24'd0);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin mtu_v = 16'd1;     dly_v = 32'd0; end
        1: begin mtu_v = 16'hFFFF;  dly_v = 32'hFFFFFFFF; end
        2: begin mtu_v = 16'd0;     dly_v = 32'd3; end
        3: begin mtu_v = 16'd8;     dly_v = 32'd100; end
        4: begin mtu_v = 16'($urandom_range(1, 2000)); dly_v = $urandom_range(0, 5000); end
        5: begin mtu_v = 16'd500;   dly_v = 32'd10000; end
        6: begin mtu_v = 16'($urandom); dly_v = $urandom; end
        default: begin mtu_v = 16'd1500; dly_v = 32'd1; end
      endcase
      wait_quiet();
      load_settings(mtu_v, dly_v);
      gaps_on = (p % 3) != 1;
      @(posedge clk);
      while (datagram_requests.size() < 250)
        queue_datagram(mtu_v, dly_v);
    end

    wait_quiet();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fsat_pkg.sv
rtl/core/fsat_div.sv
rtl/core/fsat_ram.sv
rtl/core/fragment_send_ack_tracker_unit.sv
tb/tb.sv
